### sv/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative tag directory.
// ----------------------------------------------------------------------------
package sacl_pkg;

   typedef struct packed {
      logic        op;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic        is_hit;
      logic [5:0]  set_number;
      logic [31:0] tag_value;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] tag;
      logic [31:0] stamp;
   } line_type;

   localparam int LINE_BITS = $bits(line_type);

   localparam logic [2:0] CSR_USE_FIFO       = 3'd0;
   localparam logic [2:0] CSR_WRITE_ALLOCATE = 3'd1;
   localparam logic [2:0] CSR_OFFSET_BITS    = 3'd2;
   localparam logic [2:0] CSR_INDEX_BITS     = 3'd3;
   localparam logic [2:0] CSR_WAYS_IN_USE    = 3'd4;

endpackage

### sv/set_assoc_cache_tag_lookup_core.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_core
// Tag directory of a set-associative cache with LRU or FIFO replacement.
// ----------------------------------------------------------------------------
// Flow: a request is accepted, its set row is read from the registered RAM
// output in ST_LOOK and the response is registered once the output is free.
// A new request is taken only in ST_IDLE, after the previous one is through;
// a miss on a full set adds an oldest-stamp scan over the set row first.
// Reset: synchronous; a clearing pass empties every row of the set memory,
// during which no request is accepted.
module set_assoc_cache_tag_lookup_core
   import sacl_pkg::*;
#(
   parameter int SETS = 64,
   parameter int WAYS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   localparam int IDXW = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WIDX = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROWW = WAYS * LINE_BITS;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;

   logic [2:0]       state_ff, state_in;
   logic [IDXW-1:0]  clr_ff, clr_in;

   logic             use_fifo_ff, write_alloc_ff;
   logic [4:0]       offset_bits_ff, ways_in_use_ff;
   logic [2:0]       index_bits_ff;

   logic [31:0]      count_ff, count_in;
   logic [31:0]      hits_ff, hits_in;
   logic [31:0]      misses_ff, misses_in;
   logic [31:0]      stamp_ff, stamp_in;

   logic             op_ff;
   logic [31:0]      tag_ff;
   logic [5:0]       setn_ff;
   logic [IDXW-1:0]  row_ff;
   logic [4:0]       ways_ff;
   logic [WIDX-1:0]  scan_ff, scan_in;
   logic [WIDX-1:0]  victim_ff, victim_in;
   logic [31:0]      min_ff, min_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [IDXW-1:0]  mod_tbl [128];
   logic [31:0]      shifted;
   logic [6:0]       set_full;
   logic [5:0]       total;
   logic [31:0]      tag_calc;
   logic [4:0]       ways_calc;
   logic             accept;
   logic             out_free;

   line_type [WAYS-1:0] rd_row, wr_row;
   logic [ROWW-1:0]     rd_bits;
   logic                mem_we;
   logic [IDXW-1:0]     mem_waddr;

   logic [WAYS-1:0]  hit_vec, inv_vec;
   logic             any_hit, any_inv;
   logic [WIDX-1:0]  hit_idx, inv_idx, fin_victim;
   logic             allocate;

   genvar g;
   for (g = 0; g < 128; g++) begin : g_mod
      assign mod_tbl[g] = IDXW'(g % SETS);
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      shifted   = req_payload.address >> offset_bits_ff;
      set_full  = shifted[6:0] & ((7'd1 << index_bits_ff) - 7'd1);
      total     = {1'b0, offset_bits_ff} + {3'b000, index_bits_ff};
      tag_calc  = (total >= 6'd32) ? 32'd0 : (req_payload.address >> total);
      if (ways_in_use_ff == 5'd0) begin
         ways_calc = 5'd1;
      end else if (ways_in_use_ff > 5'(WAYS)) begin
         ways_calc = 5'(WAYS);
      end else begin
         ways_calc = ways_in_use_ff;
      end
   end

   sacl_ram #(.WIDTH(ROWW), .DEPTH(SETS)) u_row_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (wr_row),
      .rd_en   (accept),
      .rd_addr (mod_tbl[set_full]),
      .rd_data (rd_bits)
   );

   assign rd_row = rd_bits;

   always_comb begin
      hit_idx = '0;
      inv_idx = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         hit_vec[w] = rd_row[w].valid && (rd_row[w].tag == tag_ff) && (5'(w) < ways_ff);
         inv_vec[w] = !rd_row[w].valid && (5'(w) < ways_ff);
         if (hit_vec[w]) begin
            hit_idx = WIDX'(w);
         end
         if (inv_vec[w]) begin
            inv_idx = WIDX'(w);
         end
      end
      any_hit  = |hit_vec;
      any_inv  = |inv_vec;
      allocate = !op_ff || write_alloc_ff;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      stamp_in     = stamp_ff;
      scan_in      = scan_ff;
      victim_in    = victim_ff;
      min_in       = min_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = row_ff;
      wr_row       = rd_row;
      fin_victim   = victim_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            wr_row    = '0;
            clr_in    = clr_ff + IDXW'(1);
            if (clr_ff == IDXW'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               stamp_in          = count_ff;
               count_in          = count_ff + 32'd1;
               rsp_valid_in      = 1'b1;
               rsp_in.is_hit     = any_hit;
               rsp_in.set_number = setn_ff;
               rsp_in.tag_value  = tag_ff;
               rsp_in.hit_total  = any_hit ? hits_ff + 32'd1 : hits_ff;
               rsp_in.miss_total = any_hit ? misses_ff : misses_ff + 32'd1;
               hits_in           = rsp_in.hit_total;
               misses_in         = rsp_in.miss_total;
               state_in          = ST_IDLE;
               if (any_hit) begin
                  if (!use_fifo_ff) begin
                     mem_we                = 1'b1;
                     wr_row[hit_idx].stamp = count_ff;
                  end
               end else if (allocate) begin
                  if (any_inv) begin
                     mem_we          = 1'b1;
                     wr_row[inv_idx] = '{valid: 1'b1, tag: tag_ff, stamp: count_ff};
                  end else if (ways_ff == 5'd1) begin
                     mem_we    = 1'b1;
                     wr_row[0] = '{valid: 1'b1, tag: tag_ff, stamp: count_ff};
                  end else begin
                     scan_in   = WIDX'(1);
                     victim_in = '0;
                     min_in    = rd_row[0].stamp;
                     state_in  = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (rd_row[scan_ff].stamp < min_ff) begin
               victim_in = scan_ff;
               min_in    = rd_row[scan_ff].stamp;
            end
            scan_in = scan_ff + WIDX'(1);
            if ({1'b0, scan_ff} == (WIDX + 1)'(ways_ff - 5'd1)) begin
               fin_victim         = victim_in;
               mem_we             = 1'b1;
               wr_row[fin_victim] = '{valid: 1'b1, tag: tag_ff, stamp: stamp_ff};
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         use_fifo_ff    <= 1'b0;
         write_alloc_ff <= 1'b1;
         offset_bits_ff <= 5'd4;
         index_bits_ff  <= 3'd6;
         ways_in_use_ff <= 5'd16;
         count_ff       <= 32'd1;
         hits_ff        <= '0;
         misses_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_USE_FIFO:       use_fifo_ff    <= csr_wdata[0];
               CSR_WRITE_ALLOCATE: write_alloc_ff <= csr_wdata[0];
               CSR_OFFSET_BITS:    offset_bits_ff <= csr_wdata;
               CSR_INDEX_BITS:     index_bits_ff  <= csr_wdata[2:0];
               CSR_WAYS_IN_USE:    ways_in_use_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      stamp_ff  <= stamp_in;
      scan_ff   <= scan_in;
      victim_ff <= victim_in;
      min_ff    <= min_in;
      if (accept) begin
         op_ff   <= req_payload.op;
         tag_ff  <= tag_calc;
         setn_ff <= set_full[5:0];
         row_ff  <= mod_tbl[set_full];
         ways_ff <= ways_calc;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOOK))
      else $error("accepted request did not start lookup");

   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("request taken during clearing pass");

   a_totals: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (state_ff != ST_LOOK)) |->
         (rsp_ff.hit_total + rsp_ff.miss_total == count_ff - 32'd1))
      else $error("hit and miss totals disagree with access count");

endmodule

### sv/sacl_ram.sv
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
